### design/mac_header_field_parser_core_macros.svh
// Assertion macros used by the checker of the header field parser.
`ifndef MAC_HEADER_FIELD_PARSER_CORE_MACROS_SVH
`define MAC_HEADER_FIELD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("header parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("header parser check failed");

`endif

### design/mhfp_pkg.sv
package mhfp_pkg;

	// Longest frame the header walk will follow before it gives up.
	localparam int MAX_FRAME_BYTES = 127;
	localparam int HDR_LIMIT = (MAX_FRAME_BYTES < 127) ? MAX_FRAME_BYTES : 127;
	localparam logic [6:0] BYTE_CNT_MAX = 7'd127;

	// Field codes reported with each byte.
	localparam logic [3:0] FC_CTL      = 4'd0;
	localparam logic [3:0] FC_SEQ      = 4'd1;
	localparam logic [3:0] FC_DPAN     = 4'd2;
	localparam logic [3:0] FC_DADDR    = 4'd3;
	localparam logic [3:0] FC_SPAN     = 4'd4;
	localparam logic [3:0] FC_SADDR    = 4'd5;
	localparam logic [3:0] FC_SUPER    = 4'd6;
	localparam logic [3:0] FC_GTS      = 4'd7;
	localparam logic [3:0] FC_GTSDIR   = 4'd8;
	localparam logic [3:0] FC_GTSLIST  = 4'd9;
	localparam logic [3:0] FC_PEND     = 4'd10;
	localparam logic [3:0] FC_PENDLIST = 4'd11;
	localparam logic [3:0] FC_CMD      = 4'd12;
	localparam logic [3:0] FC_PAYLOAD  = 4'd13;

	// Address modes and frame types that steer the walk.
	localparam logic [1:0] AM_NONE     = 2'd0;
	localparam logic [1:0] AM_RESERVED = 2'd1;
	localparam logic [1:0] AM_SHORT    = 2'd2;
	localparam logic [1:0] AM_LONG     = 2'd3;
	localparam logic [2:0] FT_BEACON   = 3'd0;
	localparam logic [2:0] FT_COMMAND  = 3'd3;

	// Header walk state, one bit per field.
	typedef enum logic [13:0] {
		ST_CTL      = 14'b00000000000001,
		ST_SEQ      = 14'b00000000000010,
		ST_DPAN     = 14'b00000000000100,
		ST_DADDR    = 14'b00000000001000,
		ST_SPAN     = 14'b00000000010000,
		ST_SADDR    = 14'b00000000100000,
		ST_SUPER    = 14'b00000001000000,
		ST_GTS      = 14'b00000010000000,
		ST_GTSDIR   = 14'b00000100000000,
		ST_GTSLIST  = 14'b00001000000000,
		ST_PEND     = 14'b00010000000000,
		ST_PENDLIST = 14'b00100000000000,
		ST_CMD      = 14'b01000000000000,
		ST_PAYLOAD  = 14'b10000000000000
	} field_state_t;

	// One request on the input channel.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} mhfp_in_t;

	// One tagged byte on the output channel.
	typedef struct packed {
		logic [7:0] byte_out;
		logic [3:0] field_code;
		logic       field_first;
		logic [2:0] frame_kind;
		logic       end_mark;
		logic       status;
	} mhfp_out_t;

	// Maps the walk state onto its reported field code.
	function automatic logic [3:0] field_code_of(input field_state_t st);
		logic [3:0] code;
		case (st)
			ST_CTL:      code = FC_CTL;
			ST_SEQ:      code = FC_SEQ;
			ST_DPAN:     code = FC_DPAN;
			ST_DADDR:    code = FC_DADDR;
			ST_SPAN:     code = FC_SPAN;
			ST_SADDR:    code = FC_SADDR;
			ST_SUPER:    code = FC_SUPER;
			ST_GTS:      code = FC_GTS;
			ST_GTSDIR:   code = FC_GTSDIR;
			ST_GTSLIST:  code = FC_GTSLIST;
			ST_PEND:     code = FC_PEND;
			ST_PENDLIST: code = FC_PENDLIST;
			ST_CMD:      code = FC_CMD;
			default:     code = FC_PAYLOAD;
		endcase
		return code;
	endfunction

	// Address mode after the reserved code has been resolved.
	function automatic logic [1:0] eff_mode(input logic [1:0] m, input logic res_short);
		logic [1:0] r;
		if (m == AM_RESERVED) begin
			r = res_short ? AM_SHORT : AM_NONE;
		end else begin
			r = m;
		end
		return r;
	endfunction

	// Address length in bytes for a mode.
	function automatic logic [6:0] addr_len(input logic [1:0] m, input logic res_short);
		return (eff_mode(m, res_short) == AM_LONG) ? 7'd8 : 7'd2;
	endfunction

endpackage

### design/mac_header_field_parser_core.sv
// An accepted request waits in the input register and moves to the output register, where its tagged byte is offered.
// Throughput: one byte per cycle, bounded only by the output handshake.
// The header walk state advances once per byte in a single combinational pass.
// Reset (arst_n low, asynchronous): both stages empty, walk at frame control,
// and the reserved-mode register set to treat mode 1 as a 16-bit address.
module mac_header_field_parser_core import mhfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      frame_valid,
	output logic      frame_ready,
	input  mhfp_in_t  frame_data,
	output logic      tag_valid,
	input  logic      tag_ready,
	output mhfp_out_t tag_data
);

	logic      valid_s1;
	mhfp_in_t  data_s1;
	logic      free;
	logic      step;
	mhfp_out_t result;

	// A request moves on when the result register can take its tag.
	assign step = valid_s1 && free;

	mhfp_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_data  (frame_data),
		.take        (step),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	mhfp_field_tracker u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (data_s1),
		.result    (result)
	);

	mhfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.free      (free),
		.tag_valid (tag_valid),
		.tag_ready (tag_ready),
		.tag_data  (tag_data)
	);

endmodule

### design/mhfp_in_stage.sv
module mhfp_in_stage import mhfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     frame_valid,
	output logic     frame_ready,
	input  mhfp_in_t frame_data,
	input  logic     take,
	output logic     valid_s1,
	output mhfp_in_t data_s1
);

	// The register may refill in the same cycle that it hands its request on.
	assign frame_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && frame_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			data_s1 <= frame_data;
		end
	end

endmodule

### design/mhfp_field_tracker.sv
module mhfp_field_tracker import mhfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      step,
	input  mhfp_in_t  item,
	output mhfp_out_t result
);

	logic         res_short_q;
	field_state_t field_q;
	logic [6:0]   left_q;
	logic         fs_q;
	logic [6:0]   byte_count_q;
	logic [2:0]   kind_q;
	logic [1:0]   dmode_q;
	logic [1:0]   smode_q;
	logic         pc_q;
	logic [2:0]   lpl_q;
	logic [2:0]   gts_q;
	logic         hc_q;

	field_state_t cur;
	logic         cut;
	logic [7:0]   b;
	field_state_t post_field;
	logic [6:0]   post_len;
	field_state_t src_field;
	logic [6:0]   src_len;
	field_state_t nxt_field;
	logic [6:0]   nxt_left;
	logic         nxt_fs;
	logic [2:0]   nxt_kind;
	logic [1:0]   nxt_dmode;
	logic [1:0]   nxt_smode;
	logic         nxt_pc;
	logic [2:0]   nxt_lpl;
	logic [2:0]   nxt_gts;
	logic         nxt_hc;

	assign b = item.frame_byte;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_short_q <= 1'b1;
		end else if (cfg_we) begin
			res_short_q <= cfg_wdata;
		end
	end

	// Field that follows the addresses, by frame type.
	always_comb begin
		if (kind_q == FT_BEACON) begin
			post_field = ST_SUPER;
			post_len   = 7'd2;
		end else if (kind_q == FT_COMMAND) begin
			post_field = ST_CMD;
			post_len   = 7'd1;
		end else begin
			post_field = ST_PAYLOAD;
			post_len   = 7'd0;
		end
	end

	// Field that opens the source part, or the post-address field if none.
	always_comb begin
		if (eff_mode(smode_q, res_short_q) == AM_NONE) begin
			src_field = post_field;
			src_len   = post_len;
		end else if (!pc_q) begin
			src_field = ST_SPAN;
			src_len   = 7'd2;
		end else begin
			src_field = ST_SADDR;
			src_len   = addr_len(smode_q, res_short_q);
		end
	end

	// Tag the current byte and work out the walk state for the next one.
	always_comb begin
		cut       = ({1'b0, byte_count_q} >= 8'(HDR_LIMIT)) && (field_q != ST_PAYLOAD);
		cur       = cut ? ST_PAYLOAD : field_q;
		nxt_field = cur;
		nxt_left  = cut ? 7'd0 : left_q;
		nxt_fs    = 1'b0;
		nxt_kind  = kind_q;
		nxt_dmode = dmode_q;
		nxt_smode = smode_q;
		nxt_pc    = pc_q;
		nxt_lpl   = lpl_q;
		nxt_gts   = gts_q;
		nxt_hc    = hc_q || cut;

		if (cur != ST_PAYLOAD) begin
			// Frame control fields, low byte first.
			if (cur == ST_CTL) begin
				if (left_q == 7'd2) begin
					nxt_kind = b[2:0];
					nxt_pc   = b[6];
				end else begin
					nxt_dmode = b[3:2];
					nxt_smode = b[7:6];
				end
			end
			nxt_left = (left_q != 7'd0) ? left_q - 7'd1 : left_q;

			// Field complete: pick the next one.
			if (nxt_left == 7'd0) begin
				nxt_fs = 1'b1;
				case (cur)
					ST_CTL: begin
						nxt_field = ST_SEQ;
						nxt_left  = 7'd1;
					end
					ST_SEQ: begin
						if (eff_mode(dmode_q, res_short_q) != AM_NONE) begin
							nxt_field = ST_DPAN;
							nxt_left  = 7'd2;
						end else begin
							nxt_field = src_field;
							nxt_left  = src_len;
						end
					end
					ST_DPAN: begin
						nxt_field = ST_DADDR;
						nxt_left  = addr_len(dmode_q, res_short_q);
					end
					ST_DADDR: begin
						nxt_field = src_field;
						nxt_left  = src_len;
					end
					ST_SPAN: begin
						nxt_field = ST_SADDR;
						nxt_left  = addr_len(smode_q, res_short_q);
					end
					ST_SADDR: begin
						nxt_field = post_field;
						nxt_left  = post_len;
					end
					ST_SUPER: begin
						nxt_field = ST_GTS;
						nxt_left  = 7'd1;
					end
					ST_GTS: begin
						nxt_gts = b[2:0];
						if (b[2:0] != 3'd0) begin
							nxt_field = ST_GTSDIR;
						end else begin
							nxt_field = ST_PEND;
						end
						nxt_left = 7'd1;
					end
					ST_GTSDIR: begin
						nxt_field = ST_GTSLIST;
						nxt_left  = {3'b000, gts_q, 1'b0} + {4'b0000, gts_q};
					end
					ST_GTSLIST: begin
						nxt_field = ST_PEND;
						nxt_left  = 7'd1;
					end
					ST_PEND: begin
						if (b[2:0] != 3'd0) begin
							nxt_field = ST_PENDLIST;
							nxt_left  = {3'b000, b[2:0], 1'b0};
							nxt_lpl   = b[6:4];
						end else if (b[6:4] != 3'd0) begin
							nxt_field = ST_PENDLIST;
							nxt_left  = 7'd8;
							nxt_lpl   = b[6:4] - 3'd1;
						end else begin
							nxt_field = ST_PAYLOAD;
							nxt_left  = 7'd0;
						end
					end
					ST_PENDLIST: begin
						// Long addresses continue the same field.
						if (lpl_q != 3'd0) begin
							nxt_lpl  = lpl_q - 3'd1;
							nxt_left = 7'd8;
							nxt_fs   = 1'b0;
						end else begin
							nxt_field = ST_PAYLOAD;
							nxt_left  = 7'd0;
						end
					end
					default: begin
						nxt_field = ST_PAYLOAD;
						nxt_left  = 7'd0;
					end
				endcase
			end
		end

		result.byte_out    = b;
		result.field_code  = field_code_of(cur);
		result.field_first = cut ? 1'b0 : fs_q;
		result.frame_kind  = kind_q;
		result.end_mark    = item.frame_last;
		result.status      = item.frame_last && ((nxt_field != ST_PAYLOAD) || nxt_hc);
	end

	// Walk state; the final byte of a frame returns it to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q      <= ST_CTL;
			left_q       <= 7'd2;
			fs_q         <= 1'b1;
			byte_count_q <= 7'd0;
			kind_q       <= 3'd0;
			dmode_q      <= AM_NONE;
			smode_q      <= AM_NONE;
			pc_q         <= 1'b0;
			lpl_q        <= 3'd0;
			gts_q        <= 3'd0;
			hc_q         <= 1'b0;
		end else if (step) begin
			if (item.frame_last) begin
				field_q      <= ST_CTL;
				left_q       <= 7'd2;
				fs_q         <= 1'b1;
				byte_count_q <= 7'd0;
				kind_q       <= 3'd0;
				dmode_q      <= AM_NONE;
				smode_q      <= AM_NONE;
				pc_q         <= 1'b0;
				lpl_q        <= 3'd0;
				gts_q        <= 3'd0;
				hc_q         <= 1'b0;
			end else begin
				field_q      <= nxt_field;
				left_q       <= nxt_left;
				fs_q         <= nxt_fs;
				if (byte_count_q != BYTE_CNT_MAX) begin
					byte_count_q <= byte_count_q + 7'd1;
				end
				kind_q       <= nxt_kind;
				dmode_q      <= nxt_dmode;
				smode_q      <= nxt_smode;
				pc_q         <= nxt_pc;
				lpl_q        <= nxt_lpl;
				gts_q        <= nxt_gts;
				hc_q         <= nxt_hc;
			end
		end
	end

endmodule

### design/mhfp_out_stage.sv
module mhfp_out_stage import mhfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  mhfp_out_t result,
	output logic      free,
	output logic      tag_valid,
	input  logic      tag_ready,
	output mhfp_out_t tag_data
);

	logic      valid_s2;
	mhfp_out_t data_s2;

	// The register takes a new result when empty or being drained.
	assign free      = !valid_s2 || tag_ready;
	assign tag_valid = valid_s2;
	assign tag_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= result;
		end
	end

endmodule

### design/mhfp_checker.sv
`include "mac_header_field_parser_core_macros.svh"

module mhfp_checker import mhfp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      frame_ready,
	input logic      tag_valid,
	input logic      tag_ready,
	input mhfp_out_t tag_data
);

	// A stalled tagged byte stays in place.
	`MHFP_ASSERT_NXT(a_out_hold, clk, arst_n, tag_valid && !tag_ready, tag_valid && $stable(tag_data))

	// A header error is only reported on the final byte of a frame.
	`MHFP_ASSERT_IMP(a_status_end, clk, arst_n, tag_valid && tag_data.status, tag_data.end_mark)

	// The first byte of a frame carries no frame type yet.
	`MHFP_ASSERT_IMP(a_first_kind, clk, arst_n, tag_valid && tag_data.field_code == FC_CTL && tag_data.field_first, tag_data.frame_kind == 3'd0)

	// With the output empty, the input side always takes a request.
	`MHFP_ASSERT_IMP(a_ready_empty, clk, arst_n, !tag_valid, frame_ready)

endmodule

bind mac_header_field_parser_core mhfp_checker u_mhfp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_ready (frame_ready),
	.tag_valid   (tag_valid),
	.tag_ready   (tag_ready),
	.tag_data    (tag_data)
);
